// ===== rtl/core/jhs_pkg.sv =====
// jhs_pkg: shared types and constants of the jacobi heat stencil solver
// used by jacobi_heat_stencil_solver and jhs_ram users; no dependencies
package jhs_pkg;

    localparam int GRID_MAX = 64;
    localparam int IDX_W    = $clog2(GRID_MAX);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int CELLS    = GRID_MAX * GRID_MAX;
    localparam int VALUE_W  = 16;
    localparam int SIZE_W   = 7;
    localparam int CNT_W    = 16;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // 100.0 in q8.8
    localparam logic [VALUE_W-1:0] START_ERROR = VALUE_W'(100 << 8);

    // register indexes on the configuration port
    localparam logic [1:0] REG_GRID_SIZE  = 2'd0;
    localparam logic [1:0] REG_TOLERANCE  = 2'd1;
    localparam logic [1:0] REG_MAX_SWEEPS = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_RUN   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [CNT_W-1:0]   sweeps_done;
        logic [VALUE_W-1:0] final_error;
    } t_result;

endpackage

// ===== rtl/core/jhs_ram.sv =====
// jhs_ram: generic single-port-write ram with one registered read port
// depends on nothing
module jhs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/jacobi_heat_stencil_solver.sv =====
// jacobi_heat_stencil_solver: 2d jacobi relaxation over a q8.8 grid in ram
// depends on jhs_pkg and jhs_ram
// one item at a time: a read or run holds busy high from the transfer until the
//   result strobe; a write or unused op leaves busy low
// reset: synchronous, active low; then a clearing pass over both
//   grid stores with busy high; configuration writes are taken meanwhile
module jacobi_heat_stencil_solver
    import jhs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command channel
    input  logic                      start,
    output logic                      busy,
    input  t_cmd                      i_cmd,
    // result channel, no back pressure
    output logic                      o_done,
    output t_result                   o_result,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_CLEAR    = 7'b0000010,
        ST_READ     = 7'b0000100,
        ST_CHECK    = 7'b0001000,
        ST_SWEEP    = 7'b0010000,
        ST_COPY     = 7'b0100000,
        ST_COPY_END = 7'b1000000
    } t_state;

    // sweep sub-steps of one interior cell
    localparam logic [1:0] PH_UD     = 2'd0;  // issue up and down reads
    localparam logic [1:0] PH_LR     = 2'd1;  // issue left and right reads
    localparam logic [1:0] PH_CENTER = 2'd2;  // issue center read
    localparam logic [1:0] PH_WRITE  = 2'd3;  // compare and write next

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [ADDR_W-1:0]    r_clr_addr, n_clr_addr;
    logic [IDX_W-1:0]     r_row, n_row;
    logic [IDX_W-1:0]     r_col, n_col;
    logic [1:0]           r_phase, n_phase;
    logic [VALUE_W:0]     r_sum, n_sum;          // up + down
    logic [VALUE_W-1:0]   r_nv, n_nv;            // new cell value
    logic [VALUE_W-1:0]   r_swp_err, n_swp_err;  // max change in this sweep
    logic [VALUE_W-1:0]   r_err, n_err;          // error seen by the loop test
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_cp_vld, n_cp_vld;
    logic [ADDR_W-1:0]    r_cp_addr, n_cp_addr;
    logic                 r_rd_inside, n_rd_inside;
    logic                 r_done, n_done;
    t_result              r_res, n_res;
    logic [SIZE_W-1:0]    r_grid_size, n_grid_size;
    logic [VALUE_W-1:0]   r_tolerance, n_tolerance;
    logic [CNT_W-1:0]     r_max_sweeps, n_max_sweeps;

    // ------------------------------------------------------------------
    // grid stores: grid_current kept in two identical copies so that two
    // neighbors can be read per cycle; grid_next in a single ram
    // ------------------------------------------------------------------
    logic                 cur_we;
    logic [ADDR_W-1:0]    cur_waddr;
    logic [VALUE_W-1:0]   cur_wdata;
    logic [ADDR_W-1:0]    cur_a_raddr, cur_b_raddr;
    logic [VALUE_W-1:0]   cur_a_rdata, cur_b_rdata;
    logic                 nxt_we;
    logic [ADDR_W-1:0]    nxt_waddr;
    logic [VALUE_W-1:0]   nxt_wdata;
    logic [ADDR_W-1:0]    nxt_raddr;
    logic [VALUE_W-1:0]   nxt_rdata;

    jhs_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_cur_a (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_raddr (cur_a_raddr),
        .o_rdata (cur_a_rdata)
    );

    jhs_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_cur_b (
        .i_clk   (i_clk),
        .i_we    (cur_we),
        .i_waddr (cur_waddr),
        .i_wdata (cur_wdata),
        .i_raddr (cur_b_raddr),
        .o_rdata (cur_b_rdata)
    );

    jhs_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_next (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (nxt_raddr),
        .o_rdata (nxt_rdata)
    );

    // ------------------------------------------------------------------
    // decode
    // ------------------------------------------------------------------
    logic                 accept;
    logic [SIZE_W-1:0]    grid_use;     // grid edge in use, clamped to GRID_MAX
    logic                 cmd_inside;
    logic [ADDR_W-1:0]    cmd_addr;
    logic [IDX_W-1:0]     last_idx;     // last interior row or column
    logic                 small_grid;   // no interior cells
    logic                 keep_going;
    logic [ADDR_W-1:0]    cell_addr;
    logic [VALUE_W+1:0]   sum4;
    logic [VALUE_W-1:0]   diff;
    logic [VALUE_W-1:0]   err_upd;
    logic                 col_last, row_last;
    logic                 cfg_wr;

    assign accept     = start && !busy;
    assign grid_use   = (r_grid_size > SIZE_W'(GRID_MAX)) ? SIZE_W'(GRID_MAX) : r_grid_size;
    assign cmd_inside = ({1'b0, i_cmd.row} < grid_use) && ({1'b0, i_cmd.col} < grid_use);
    assign cmd_addr   = {i_cmd.row, i_cmd.col};
    assign small_grid = grid_use < SIZE_W'(3);
    assign last_idx   = IDX_W'(grid_use - SIZE_W'(2));
    assign keep_going = (r_err > r_tolerance) && (r_count < r_max_sweeps);
    assign cell_addr  = {r_row, r_col};
    assign col_last   = (r_col == last_idx);
    assign row_last   = (r_row == last_idx);

    // full sum of the four neighbors; the truncated quarter is taken in the center step
    assign sum4 = {1'b0, r_sum} + (VALUE_W+2)'(cur_a_rdata) + (VALUE_W+2)'(cur_b_rdata);

    // absolute change against the center value that arrives in the write step
    assign diff    = (r_nv > cur_a_rdata) ? (r_nv - cur_a_rdata) : (cur_a_rdata - r_nv);
    assign err_upd = (diff > r_swp_err) ? diff : r_swp_err;

    // ------------------------------------------------------------------
    // memory port muxing; sweeps only read current and write next, the
    // copy only reads next and writes current, so accesses never collide
    // ------------------------------------------------------------------
    always_comb begin
        cur_a_raddr = cmd_addr;
        cur_b_raddr = cmd_addr;
        if (r_state == ST_SWEEP) begin
            case (r_phase)
                PH_UD: begin
                    cur_a_raddr = {r_row - IDX_W'(1), r_col};
                    cur_b_raddr = {r_row + IDX_W'(1), r_col};
                end
                PH_LR: begin
                    cur_a_raddr = {r_row, r_col - IDX_W'(1)};
                    cur_b_raddr = {r_row, r_col + IDX_W'(1)};
                end
                default: begin
                    cur_a_raddr = cell_addr;
                    cur_b_raddr = cell_addr;
                end
            endcase
        end
    end

    assign nxt_raddr = cell_addr;

    always_comb begin
        cur_we    = 1'b0;
        cur_waddr = cmd_addr;
        cur_wdata = i_cmd.value;
        nxt_we    = 1'b0;
        nxt_waddr = cmd_addr;
        nxt_wdata = i_cmd.value;
        if (r_state == ST_CLEAR) begin
            cur_we    = 1'b1;
            cur_waddr = r_clr_addr;
            cur_wdata = '0;
            nxt_we    = 1'b1;
            nxt_waddr = r_clr_addr;
            nxt_wdata = '0;
        end else begin
            // a cell write goes into both stores
            if (accept && i_cmd.op == OP_WRITE && cmd_inside) begin
                cur_we = 1'b1;
                nxt_we = 1'b1;
            end
            // copy back: data read from next in the previous cycle
            if (r_cp_vld) begin
                cur_we    = 1'b1;
                cur_waddr = r_cp_addr;
                cur_wdata = nxt_rdata;
            end
            if (r_state == ST_SWEEP && r_phase == PH_WRITE) begin
                nxt_we    = 1'b1;
                nxt_waddr = cell_addr;
                nxt_wdata = r_nv;
            end
        end
    end

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        n_grid_size  = r_grid_size;
        n_tolerance  = r_tolerance;
        n_max_sweeps = r_max_sweeps;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_GRID_SIZE:  n_grid_size  = pwdata[SIZE_W-1:0];
                REG_TOLERANCE:  n_tolerance  = pwdata[VALUE_W-1:0];
                REG_MAX_SWEEPS: n_max_sweeps = pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GRID_SIZE:  prdata = PDATA_W'(r_grid_size);
            REG_TOLERANCE:  prdata = PDATA_W'(r_tolerance);
            REG_MAX_SWEEPS: prdata = PDATA_W'(r_max_sweeps);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_row       = r_row;
        n_col       = r_col;
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_nv        = r_nv;
        n_swp_err   = r_swp_err;
        n_err       = r_err;
        n_count     = r_count;
        n_cp_vld    = 1'b0;
        n_cp_addr   = r_cp_addr;
        n_rd_inside = r_rd_inside;
        n_done      = 1'b0;
        n_res       = r_res;

        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    case (i_cmd.op)
                        OP_RUN: begin
                            n_err   = START_ERROR;
                            n_count = '0;
                            n_state = ST_CHECK;
                        end
                        OP_READ: begin
                            // read issued on port a this cycle
                            n_rd_inside = cmd_inside;
                            n_state     = ST_READ;
                        end
                        default: begin
                            // write, or unused op: empty result
                            n_done = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ: begin
                n_done           = 1'b1;
                n_res.read_value = r_rd_inside ? cur_a_rdata : '0;
                n_state          = ST_IDLE;
            end

            ST_CHECK: begin
                if (!keep_going) begin
                    n_done            = 1'b1;
                    n_res.sweeps_done = r_count;
                    n_res.final_error = r_err;
                    n_state           = ST_IDLE;
                end else if (small_grid) begin
                    // nothing to relax: sweep with zero change
                    n_err   = '0;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_row     = IDX_W'(1);
                    n_col     = IDX_W'(1);
                    n_phase   = PH_UD;
                    n_swp_err = '0;
                    n_state   = ST_SWEEP;
                end
            end

            ST_SWEEP: begin
                n_phase = r_phase + 2'd1;
                case (r_phase)
                    PH_LR:     n_sum = {1'b0, cur_a_rdata} + {1'b0, cur_b_rdata};
                    PH_CENTER: n_nv  = sum4[VALUE_W+1:2];
                    PH_WRITE: begin
                        n_swp_err = err_upd;
                        if (col_last) begin
                            n_col = IDX_W'(1);
                            if (row_last) begin
                                n_err   = err_upd;
                                n_row   = IDX_W'(1);
                                n_state = ST_COPY;
                            end else begin
                                n_row = r_row + IDX_W'(1);
                            end
                        end else begin
                            n_col = r_col + IDX_W'(1);
                        end
                    end
                    default: ;
                endcase
            end

            ST_COPY: begin
                // one interior cell per cycle, written back in the following cycle
                n_cp_vld  = 1'b1;
                n_cp_addr = cell_addr;
                if (col_last) begin
                    n_col = IDX_W'(1);
                    if (row_last) begin
                        n_state = ST_COPY_END;
                    end else begin
                        n_row = r_row + IDX_W'(1);
                    end
                end else begin
                    n_col = r_col + IDX_W'(1);
                end
            end

            ST_COPY_END: begin
                // last copy write lands this cycle
                n_count = r_count + CNT_W'(1);
                n_state = ST_CHECK;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_cp_vld     <= 1'b0;
            r_done       <= 1'b0;
            r_grid_size  <= SIZE_W'(GRID_MAX);
            r_tolerance  <= '0;
            r_max_sweeps <= '0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_cp_vld     <= n_cp_vld;
            r_done       <= n_done;
            r_grid_size  <= n_grid_size;
            r_tolerance  <= n_tolerance;
            r_max_sweeps <= n_max_sweeps;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_col       <= n_col;
        r_phase     <= n_phase;
        r_sum       <= n_sum;
        r_nv        <= n_nv;
        r_swp_err   <= n_swp_err;
        r_err       <= n_err;
        r_count     <= n_count;
        r_cp_addr   <= n_cp_addr;
        r_rd_inside <= n_rd_inside;
        r_res       <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // a write or unused op is answered in the very next cycle
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.op == OP_WRITE || i_cmd.op == OP_NONE)) |=> r_done)
        else $error("write transfer not answered next cycle");

    // copy-back writes only follow copy reads
    a_copy_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_vld |-> (r_state == ST_COPY || r_state == ST_COPY_END))
        else $error("copy write outside copy phase");

    // no result strobe while the clearing pass runs
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_done)
        else $error("result during clearing pass");

    // a run result never reports more sweeps than allowed
    a_sweep_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == ST_CHECK) && r_done) |-> (r_res.sweeps_done <= r_max_sweeps))
        else $error("sweep count above limit");
`endif

endmodule

// ===== dv/tb_jacobi_heat_stencil_solver.sv =====
// tb_jacobi_heat_stencil_solver: self-checking testbench for the jacobi heat stencil solver
// drives cell writes, reads and solver runs and checks them against a behavioral grid model
// depends on jhs_pkg and the solver rtl only
module tb_jacobi_heat_stencil_solver;
    timeunit 1ns;
    timeprecision 1ps;
    import jhs_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 200;
    localparam int MAX_GAP      = 5;
    // address slot past the last register, writes there must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // one row of the directed plan: either a register write or a command
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        t_cmd        cmd;
        bit          typed;
        t_result     want;
    } t_plan_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_cmd                 i_cmd;
    logic                 o_done;
    t_result              o_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // shadow copy of both grid stores and of the three registers
    logic [VALUE_W-1:0]   shadow_cur [CELLS];
    logic [VALUE_W-1:0]   shadow_nxt [CELLS];
    logic [SIZE_W-1:0]    shadow_size;
    logic [VALUE_W-1:0]   shadow_tol;
    logic [CNT_W-1:0]     shadow_max;

    t_result              awaited_results [$];
    t_plan_row            plan [$];
    int                   error_count       = 0;
    int                   cycle_count       = 0;
    int                   random_items_sent = 0;

    jacobi_heat_stencil_solver uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // one jacobi sweep over the interior of an n by n grid, returns the largest change
    function automatic int relax_sweep(int n);
        int worst, at, sum, nv, old, d;
        worst = 0;
        for (int r = 1; r + 1 < n; r++) begin
            for (int c = 1; c + 1 < n; c++) begin
                at  = r * GRID_MAX + c;
                sum = int'(shadow_cur[at + GRID_MAX]) + int'(shadow_cur[at - GRID_MAX])
                    + int'(shadow_cur[at - 1]) + int'(shadow_cur[at + 1]);
                // quarter of the sum, truncated
                nv  = (sum >> 2) & 32'hFFFF;
                old = int'(shadow_cur[at]);
                d   = (nv > old) ? nv - old : old - nv;
                shadow_nxt[at] = VALUE_W'(nv);
                if (d > worst) worst = d;
            end
        end
        // interior goes back into the current store, boundary never moves
        for (int r = 1; r + 1 < n; r++) begin
            for (int c = 1; c + 1 < n; c++) begin
                shadow_cur[r * GRID_MAX + c] = shadow_nxt[r * GRID_MAX + c];
            end
        end
        return worst;
    endfunction

    // effect of one command on the shadow grid and the result it must produce
    function automatic t_result heat_step(t_cmd c);
        t_result res;
        int      n, at, err, cnt;
        bit      in_grid;
        res = '0;
        // sizes above the store act as the full store
        n       = (int'(shadow_size) > GRID_MAX) ? GRID_MAX : int'(shadow_size);
        in_grid = (int'(c.row) < n) && (int'(c.col) < n);
        at      = int'(c.row) * GRID_MAX + int'(c.col);
        case (c.op)
            OP_WRITE: begin
                if (in_grid) begin
                    shadow_cur[at] = c.value;
                    shadow_nxt[at] = c.value;
                end
            end
            OP_RUN: begin
                // error starts at 100.0, so a tolerance at or above it means no sweep
                err = int'(START_ERROR);
                cnt = 0;
                while (err > int'(shadow_tol) && cnt < int'(shadow_max)) begin
                    err = relax_sweep(n);
                    cnt++;
                end
                res.sweeps_done = CNT_W'(cnt);
                res.final_error = VALUE_W'(err);
            end
            OP_READ: begin
                if (in_grid) res.read_value = shadow_cur[at];
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void plan_cmd(t_op op, int r, int c, logic [VALUE_W-1:0] v,
                                     bit typed = 1'b0, t_result want = '0);
        t_plan_row p;
        p           = '{default: '0};
        p.cmd.op    = op;
        p.cmd.row   = IDX_W'(r);
        p.cmd.col   = IDX_W'(c);
        p.cmd.value = v;
        p.typed     = typed;
        p.want      = want;
        plan.push_back(p);
    endfunction

    function automatic void plan_cfg(logic [1:0] idx, logic [31:0] v);
        t_plan_row p;
        p         = '{default: '0};
        p.is_cfg  = 1'b1;
        p.reg_idx = idx;
        p.reg_val = v;
        plan.push_back(p);
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        if (error_count < MAX_REPORTS)
            $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // apb write, then a read back of the same register where it exists
    task automatic write_register(logic [1:0] idx, logic [31:0] data);
        logic [31:0] mask;
        mask    = (idx == REG_GRID_SIZE) ? 32'h7F : 32'hFFFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // register taken at this edge
        case (idx)
            REG_GRID_SIZE:  shadow_size = data[SIZE_W-1:0];
            REG_TOLERANCE:  shadow_tol  = data[VALUE_W-1:0];
            REG_MAX_SWEEPS: shadow_max  = data[CNT_W-1:0];
            default: ;
        endcase
        if (idx != REG_UNUSED) begin
            pwrite  <= 1'b0;
            penable <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== (data & mask))
                report_mismatch("register read back", 48'(prdata), 48'(data & mask));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold off the sender until every awaited result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // one command transfer after an optional gap; start stays high for a back-to-back item
    task automatic send_cmd(t_cmd c, int gap, bit typed, t_result want);
        t_result predicted;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        predicted = heat_step(c);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    // result side: every strobe is matched with the oldest awaited result
    always @(posedge i_clk) begin : result_check
        t_result want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_jacobi_heat_stencil_solver: done, errors");
            $finish;
        end else if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited", o_result, '0);
            end else begin
                want = awaited_results.pop_front();
                if (o_result.read_value !== want.read_value)
                    report_mismatch("read_value", 48'(o_result.read_value),
                                    48'(want.read_value));
                if (o_result.sweeps_done !== want.sweeps_done)
                    report_mismatch("sweeps_done", 48'(o_result.sweeps_done),
                                    48'(want.sweeps_done));
                if (o_result.final_error !== want.final_error)
                    report_mismatch("final_error", 48'(o_result.final_error),
                                    48'(want.final_error));
            end
        end
    end

    initial begin : stimulus
        t_cmd        c;
        int          n, phase_len, run_pct, pick, gap;
        bit          idle_on;
        logic [6:0]  gs;
        logic [15:0] tol, ms;
        logic [31:0] junk;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_cmd   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;

        // reset state of the block: empty grids, full-size grid, no tolerance, no sweeps
        foreach (shadow_cur[k]) begin
            shadow_cur[k] = '0;
            shadow_nxt[k] = '0;
        end
        shadow_size = SIZE_W'(GRID_MAX);
        shadow_tol  = '0;
        shadow_max  = '0;

        // directed plan, starting from the reset settings
        plan_cmd(OP_READ, 0, 0, 16'h0000, 1'b1, '0);
        plan_cmd(OP_READ, 63, 63, 16'hFFFF, 1'b1, '0);
        // max_sweeps is zero after reset: no sweep, error stays at 100.0
        plan_cmd(OP_RUN, 0, 0, 16'h0000, 1'b1, '{16'h0, 16'h0, START_ERROR});
        plan_cmd(OP_WRITE, 0, 0, 16'hFFFF, 1'b1, '0);
        plan_cmd(OP_READ, 0, 0, 16'h0000, 1'b1, '{16'hFFFF, 16'h0, 16'h0});
        plan_cmd(OP_WRITE, 63, 63, 16'hAAAA, 1'b1, '0);
        plan_cmd(OP_READ, 63, 63, 16'h0000, 1'b1, '{16'hAAAA, 16'h0, 16'h0});
        plan_cmd(OP_WRITE, 40, 40, 16'h5555, 1'b1, '0);
        // unused op gives an all-zero result
        plan_cmd(OP_NONE, 63, 63, 16'hFFFF, 1'b1, '0);
        plan_cmd(OP_NONE, 0, 0, 16'h0000, 1'b1, '0);
        plan_cfg(REG_GRID_SIZE, 32'd5);
        plan_cfg(REG_MAX_SWEEPS, 32'd4);
        // cell outside the grid: reads 0, write is dropped
        plan_cmd(OP_READ, 40, 40, 16'h0000, 1'b1, '0);
        plan_cmd(OP_WRITE, 40, 40, 16'h1234, 1'b1, '0);
        plan_cmd(OP_WRITE, 0, 2, 16'hFFFF, 1'b1, '0);
        plan_cmd(OP_WRITE, 4, 2, 16'h8000, 1'b1, '0);
        plan_cmd(OP_WRITE, 2, 0, 16'h0100, 1'b1, '0);
        plan_cmd(OP_WRITE, 2, 2, 16'h00FF, 1'b1, '0);
        plan_cmd(OP_RUN, 0, 0, 16'h0000);
        plan_cmd(OP_READ, 2, 2, 16'h0000);
        // oversized grid acts as the full store; cells kept across size changes
        plan_cfg(REG_GRID_SIZE, 32'd127);
        plan_cfg(REG_MAX_SWEEPS, 32'd0);
        plan_cmd(OP_READ, 40, 40, 16'h0000, 1'b1, '{16'h5555, 16'h0, 16'h0});
        // tiny grid has no interior: one sweep with zero error
        plan_cfg(REG_GRID_SIZE, 32'd2);
        plan_cfg(REG_MAX_SWEEPS, 32'hFFFF);
        plan_cmd(OP_RUN, 0, 0, 16'h0000, 1'b1, '{16'h0, 16'h1, 16'h0});
        // tolerance not below 100.0: no sweep at all
        plan_cfg(REG_GRID_SIZE, 32'd64);
        plan_cfg(REG_TOLERANCE, 32'hFFFF);
        plan_cmd(OP_RUN, 63, 63, 16'hFFFF, 1'b1, '{16'h0, 16'h0, START_ERROR});
        // one full-size sweep; the write past the last register must change nothing
        plan_cfg(REG_TOLERANCE, 32'd0);
        plan_cfg(REG_MAX_SWEEPS, 32'd1);
        plan_cfg(REG_UNUSED, 32'hFFFF_FFFF);
        plan_cmd(OP_RUN, 0, 0, 16'h0000);
        // zero-size grid: every cell is outside
        plan_cfg(REG_GRID_SIZE, 32'd0);
        plan_cmd(OP_WRITE, 0, 0, 16'h1234, 1'b1, '0);
        plan_cmd(OP_READ, 0, 0, 16'h0000, 1'b1, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing pass after reset shows up as busy on the first transfer

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                drain_results();
                write_register(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                send_cmd(plan[k].cmd, $urandom_range(0, MAX_GAP), plan[k].typed, plan[k].want);
            end
        end

        // random phases: settings change only once the block has gone quiet
        while (random_items_sent < RANDOM_ITEMS) begin
            drain_results();
            case ($urandom_range(0, 9))
                0: begin
                    // tiny grid, any tolerance, sweep limit up to the maximum
                    gs      = 7'($urandom_range(0, 2));
                    tol     = 16'($urandom);
                    ms      = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
                    run_pct = 15;
                end
                1, 2, 3, 4, 5: begin
                    gs      = 7'($urandom_range(3, 8));
                    ms      = 16'($urandom_range(0, 10));
                    run_pct = 12;
                end
                6, 7: begin
                    gs      = 7'($urandom_range(9, 16));
                    ms      = 16'($urandom_range(0, 3));
                    run_pct = 6;
                end
                8: begin
                    // grids from near the full store up to beyond it
                    gs      = 7'($urandom_range(60, 127));
                    ms      = 16'($urandom_range(0, 1));
                    run_pct = 3;
                end
                default: begin
                    // runs that never sweep, whatever the limit
                    gs      = 7'($urandom_range(0, 127));
                    tol     = 16'($urandom_range(int'(START_ERROR), 65535));
                    ms      = 16'($urandom_range(11, 65535));
                    run_pct = 15;
                end
            endcase
            if (gs >= 3 && tol < START_ERROR || gs >= 3 && ms <= 16'd10) begin
                case ($urandom_range(0, 5))
                    0, 1:    tol = 16'h0000;
                    2:       tol = 16'($urandom_range(0, 255));
                    3:       tol = 16'($urandom_range(0, 2048));
                    4:       tol = START_ERROR - 16'd1;
                    default: tol = START_ERROR;
                endcase
            end
            // upper data bits are junk half the time, the register keeps only its width
            junk = $urandom_range(0, 1) ? $urandom : 32'h0;
            write_register(REG_GRID_SIZE, (junk & ~32'h7F) | 32'(gs));
            write_register(REG_TOLERANCE, (junk & ~32'hFFFF) | 32'(tol));
            write_register(REG_MAX_SWEEPS, (junk & ~32'hFFFF) | 32'(ms));
            if ($urandom_range(0, 7) == 0) write_register(REG_UNUSED, $urandom);

            n         = (int'(gs) > GRID_MAX) ? GRID_MAX : int'(gs);
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(60, 110);
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < run_pct)
                    c.op = OP_RUN;
                else if (pick < run_pct + 3)
                    c.op = OP_NONE;
                else if (pick < run_pct + 48)
                    c.op = OP_WRITE;
                else
                    c.op = OP_READ;
                // mostly cells inside the grid, the rest anywhere in the store
                if (n > 0 && $urandom_range(0, 99) < 85) begin
                    c.row = IDX_W'($urandom_range(0, n - 1));
                    c.col = IDX_W'($urandom_range(0, n - 1));
                end else begin
                    c.row = IDX_W'($urandom_range(0, 63));
                    c.col = IDX_W'($urandom_range(0, 63));
                end
                case ($urandom_range(0, 9))
                    0:       c.value = 16'h0000;
                    1:       c.value = 16'hFFFF;
                    default: c.value = 16'($urandom);
                endcase
                gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
                // now and then the sender waits for all results before going on
                if ($urandom_range(0, 49) == 0) drain_results();
                send_cmd(c, gap, 1'b0, '0);
                random_items_sent++;
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_jacobi_heat_stencil_solver: done, clean");
        end else begin
            $display("tb_jacobi_heat_stencil_solver: done, errors");
        end
        $finish;
    end

endmodule
